// ===== design/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utt_pkg;

  // Replacement unit for any ill-formed input
  localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
  // Code point limits and surrogate bases
  localparam logic [20:0] MAX_POINT     = 21'h10FFFF;
  localparam logic [20:0] SURR_LOW      = 21'h00D800;
  localparam logic [20:0] SURR_HIGH     = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] MIN_TWO_BYTE  = 21'h000080;
  localparam logic [20:0] MIN_THREE     = 21'h000800;
  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;

  // Named continuation byte counts of a sequence
  localparam logic [1:0] EXTRA_NONE  = 2'd0;
  localparam logic [1:0] EXTRA_ONE   = 2'd1;
  localparam logic [1:0] EXTRA_TWO   = 2'd2;
  localparam logic [1:0] EXTRA_THREE = 2'd3;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  // One output beat
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_end;
    logic        string_end;
  } out_t;

  // Pending multi-byte sequence
  typedef struct packed {
    logic [20:0] point;
    logic [1:0]  remaining;
    logic [1:0]  extra;
  } seq_state_t;

  // Units produced by one input byte
  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        last;
  } unit_pair_t;

endpackage : utt_pkg

`default_nettype wire

// ===== design/utt_decode.sv =====
// ----------------------------------------------------------------------------
// utt_decode
// Combinational decode of one UTF-8 byte against the pending sequence state:
// gives the next sequence state and up to two UTF-16 code units.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_decode (
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  input  utt_pkg::seq_state_t state_i,
  output utt_pkg::seq_state_t state_o,
  output utt_pkg::unit_pair_t units_o
);
  import utt_pkg::*;

  logic        is_cont;
  logic        lead_starts;
  logic        lead_cnt;
  logic [15:0] lead_unit;
  seq_state_t  lead_state;
  logic [20:0] joined_point;
  logic [1:0]  rem_dec;
  logic        bad_point;
  logic [20:0] final_point;
  logic [20:0] supp_offset;
  logic        needs_pair;

  assign is_cont = (data_byte_i[7:6] == 2'b10);

  // Classify the byte as a lead byte
  always_comb begin
    lead_state  = '0;
    lead_cnt    = 1'b0;
    lead_unit   = REPLACEMENT;
    lead_starts = 1'b0;
    priority if (!data_byte_i[7]) begin
      lead_cnt  = 1'b1;
      lead_unit = {8'h00, data_byte_i};
    end else if (data_byte_i[7:5] == 3'b110) begin
      lead_starts          = 1'b1;
      lead_state.point     = {16'h0000, data_byte_i[4:0]};
      lead_state.extra     = EXTRA_ONE;
      lead_state.remaining = EXTRA_ONE;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_starts          = 1'b1;
      lead_state.point     = {17'd0, data_byte_i[3:0]};
      lead_state.extra     = EXTRA_TWO;
      lead_state.remaining = EXTRA_TWO;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_starts          = 1'b1;
      lead_state.point     = {18'd0, data_byte_i[2:0]};
      lead_state.extra     = EXTRA_THREE;
      lead_state.remaining = EXTRA_THREE;
    end else begin
      // stray continuation or invalid lead
      lead_cnt = 1'b1;
    end
    // drop a sequence that starts on the string's last byte
    if (lead_starts && final_byte_i) begin
      lead_state = '0;
      lead_cnt   = 1'b1;
      lead_unit  = REPLACEMENT;
    end
  end

  // Append the continuation bits and check the finished code point
  assign joined_point = {state_i.point[14:0], data_byte_i[5:0]};
  assign rem_dec      = state_i.remaining - 2'd1;

  always_comb begin
    bad_point = (joined_point > MAX_POINT) ||
                ((joined_point >= SURR_LOW) && (joined_point <= SURR_HIGH));
    unique case (state_i.extra)
      EXTRA_ONE:   bad_point = bad_point || (joined_point < MIN_TWO_BYTE);
      EXTRA_TWO:   bad_point = bad_point || (joined_point < MIN_THREE);
      EXTRA_THREE: bad_point = bad_point || (joined_point < SUPP_BASE);
      default:     bad_point = 1'b1;
    endcase
  end

  assign final_point = bad_point ? {5'b00000, REPLACEMENT} : joined_point;
  assign needs_pair  = |final_point[20:16];
  assign supp_offset = final_point - SUPP_BASE;

  // Select the units and the next state
  always_comb begin
    state_o       = state_i;
    units_o.count = 2'd0;
    units_o.unit0 = REPLACEMENT;
    units_o.unit1 = REPLACEMENT;
    units_o.last  = final_byte_i;
    if (state_i.remaining != EXTRA_NONE) begin
      if (is_cont) begin
        if (rem_dec == EXTRA_NONE) begin
          state_o = '0;
          if (needs_pair) begin
            units_o.count = 2'd2;
            units_o.unit0 = {HIGH_SURR_TAG, supp_offset[19:10]};
            units_o.unit1 = {LOW_SURR_TAG, supp_offset[9:0]};
          end else begin
            units_o.count = 2'd1;
            units_o.unit0 = final_point[15:0];
          end
        end else if (final_byte_i) begin
          state_o       = '0;
          units_o.count = 2'd1;
        end else begin
          state_o.point     = joined_point;
          state_o.remaining = rem_dec;
        end
      end else begin
        // break off the sequence, then handle the byte as a lead
        state_o       = lead_state;
        units_o.count = 2'd1 + {1'b0, lead_cnt};
        units_o.unit1 = lead_unit;
      end
    end else begin
      state_o       = lead_state;
      units_o.count = {1'b0, lead_cnt};
      units_o.unit0 = lead_unit;
    end
  end

endmodule : utt_decode

`default_nettype wire

// ===== design/utt_out_buf.sv =====
// ----------------------------------------------------------------------------
// utt_out_buf
// Two-slot result register: loads one or two code units at once and hands
// them out one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_en_i,
  input  utt_pkg::unit_pair_t load_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output utt_pkg::out_t       out_data_o
);
  import utt_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  out_t       slot0_q, slot0_d;
  out_t       slot1_q, slot1_d;
  logic       pop;

  assign pop    = (cnt_q != 2'd0) && !out_stall_i;
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);

  // Load a new pair or shift the second slot forward
  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_en_i) begin
      cnt_d              = load_i.count;
      slot0_d.code_unit  = load_i.unit0;
      slot0_d.run_end    = (load_i.count == 2'd1);
      slot0_d.string_end = (load_i.count == 2'd1) && load_i.last;
      slot1_d.code_unit  = load_i.unit1;
      slot1_d.run_end    = 1'b1;
      slot1_d.string_end = load_i.last;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en_i |-> free_o && (load_i.count != 2'd0))
    else $error("result buffer loaded while occupied");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
`endif

endmodule : utt_out_buf

`default_nettype wire

// ===== design/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out, ill-formed input replaced.
// ----------------------------------------------------------------------------
// Input channel: one UTF-8 byte per beat, final_byte marks the string's last
// byte. Output channel: one UTF-16 code unit per beat; run_end marks the last
// unit caused by a byte, string_end the last unit of the string.
// Path: an accepted byte is held in the input register, decoded out of it and
// loaded into the result register, which presents its first unit.
// Throughput: one byte per cycle while each byte yields at most one unit and
// the receiver does not stall; a byte that yields two units (surrogate pair,
// or a replacement followed by the interrupting byte's own unit) occupies the
// output for both. The rate is set by the single output port draining the
// two-slot result register; bytes that yield no unit pass through without using it.
// Reset clears the pending sequence, the input register and the result
// register; no beat is presented until a byte arrives.
// When the receiver stalls, the current unit holds; the block keeps taking
// bytes until the input register is also held, then raises in_stall_o.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  utt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output utt_pkg::out_t  out_data_o
);
  import utt_pkg::*;

  logic       in_vq_q, in_vq_d;
  in_t        in_q;
  seq_state_t state_q;
  seq_state_t state_next;
  unit_pair_t dec_units;
  logic       buf_free;
  logic       advance;
  logic       load_en;
  logic       in_take;

  // Decode the held byte
  utt_decode u_decode (
    .data_byte_i  (in_q.data_byte),
    .final_byte_i (in_q.final_byte),
    .state_i      (state_q),
    .state_o      (state_next),
    .units_o      (dec_units)
  );

  // Advance the held byte when its units fit in the result register
  assign advance    = in_vq_q && ((dec_units.count == 2'd0) || buf_free);
  assign load_en    = advance && (dec_units.count != 2'd0);
  assign in_stall_o = in_vq_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vq_d = in_vq_q;
    if (in_take) begin
      in_vq_d = 1'b1;
    end else if (advance) begin
      in_vq_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq_q <= 1'b0;
      state_q <= '0;
    end else begin
      in_vq_q <= in_vq_d;
      if (advance) begin
        state_q <= state_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Hold results for the receiver
  utt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_en_i   (load_en),
    .load_i      (dec_units),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_state_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.remaining != EXTRA_NONE) |->
      (state_q.extra != EXTRA_NONE) && (state_q.remaining <= state_q.extra))
    else $error("pending count exceeds sequence length");
  a_final_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.final_byte) |=> (state_q.remaining == EXTRA_NONE))
    else $error("sequence left pending after final byte");
  a_final_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.final_byte) |-> load_en)
    else $error("final byte produced no unit");
  a_string_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.string_end) |-> out_data_o.run_end)
    else $error("string end without run end");
`endif

endmodule : utf8_to_utf16_transcoder

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
// A driver feeds UTF-8 bytes from a queue filled by the stimulus process: a
// short directed string set, then random strings that are mostly well formed
// and are mixed with overlong, surrogate, out-of-range, stray, invalid,
// interrupted and truncated sequences. A decoder copy in the monitor works out
// the UTF-16 units expected for each accepted byte. Each unit the block
// presents is checked field by field against the oldest expected unit. Both
// sides idle at random in two of the three modes, and the receiver holds off once for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utt_pkg::*;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  utf8_to_utf16_transcoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Bytes waiting to be driven, and units the decoder copy expects
  in_t        byte_q[$];
  out_t       expected_units[$];
  logic [7:0] string_bytes[$];
  int         bytes_queued  = 0;
  int         bytes_taken   = 0;
  int         mismatches    = 0;
  logic       in_beat_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         idle_mode     = 0;
  logic       hold_off      = 1'b0;

  // Decoder copy: pending sequence and units of the current byte
  logic [20:0] seq_point;
  logic [1:0]  seq_left;
  logic [1:0]  seq_need;
  logic [15:0] unit_buf[2];
  int          unit_cnt;

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void emit_unit(input logic [15:0] unit);
    unit_buf[unit_cnt] = unit;
    unit_cnt++;
  endfunction

  function automatic void clear_sequence();
    seq_point = '0;
    seq_left  = EXTRA_NONE;
    seq_need  = EXTRA_NONE;
  endfunction

  // Close a completed sequence: check its range, emit one unit or a pair
  function automatic void finish_point();
    logic [20:0] cp;
    logic [20:0] offset;
    logic        bad;
    cp  = seq_point;
    bad = (cp > MAX_POINT) || (cp >= SURR_LOW && cp <= SURR_HIGH) ||
          (seq_need == EXTRA_ONE && cp < MIN_TWO_BYTE) ||
          (seq_need == EXTRA_TWO && cp < MIN_THREE) ||
          (seq_need == EXTRA_THREE && cp < SUPP_BASE);
    if (bad) begin
      emit_unit(REPLACEMENT);
    end else if (cp < SUPP_BASE) begin
      emit_unit(cp[15:0]);
    end else begin
      offset = cp - SUPP_BASE;
      emit_unit({HIGH_SURR_TAG, offset[19:10]});
      emit_unit({LOW_SURR_TAG, offset[9:0]});
    end
    clear_sequence();
  endfunction

  // Treat a byte as the start of a new code point
  function automatic void start_lead(input logic [7:0] b, input logic last);
    if (b[7] == 1'b0) begin
      emit_unit({8'h00, b});
      return;
    end
    if (b[7:5] == 3'b110) begin
      seq_point = {16'h0, b[4:0]};
      seq_need  = EXTRA_ONE;
    end else if (b[7:4] == 4'b1110) begin
      seq_point = {17'h0, b[3:0]};
      seq_need  = EXTRA_TWO;
    end else if (b[7:3] == 5'b11110) begin
      seq_point = {18'h0, b[2:0]};
      seq_need  = EXTRA_THREE;
    end else begin
      emit_unit(REPLACEMENT);
      return;
    end
    seq_left = seq_need;
    // A sequence cut off by the string end gives one replacement
    if (last) begin
      emit_unit(REPLACEMENT);
      clear_sequence();
    end
  endfunction

  // Work out the units caused by one accepted byte and queue them
  function automatic void decode_beat(input in_t beat);
    logic [7:0] b;
    logic       last;
    out_t       unit;
    b        = beat.data_byte;
    last     = beat.final_byte;
    unit_cnt = 0;
    if (seq_left != EXTRA_NONE) begin
      if (b[7:6] == 2'b10) begin
        seq_point = {seq_point[14:0], b[5:0]};
        seq_left  = seq_left - 2'd1;
        if (seq_left == EXTRA_NONE) begin
          finish_point();
        end else if (last) begin
          emit_unit(REPLACEMENT);
          clear_sequence();
        end
      end else begin
        // Replace the broken sequence, then decode the byte afresh
        emit_unit(REPLACEMENT);
        clear_sequence();
        start_lead(b, last);
      end
    end else begin
      start_lead(b, last);
    end
    for (int i = 0; i < unit_cnt; i++) begin
      unit.code_unit  = unit_buf[i];
      unit.run_end    = (i == unit_cnt - 1);
      unit.string_end = (i == unit_cnt - 1) && last;
      expected_units  = {expected_units, unit};
    end
  endfunction

  // Input driver: advance on an accepted beat, hold a stalled one
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_beat_taken)) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= byte_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: random, or forced during the hold-off
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      in_beat_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        decode_beat(in_data_i);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_units.size() == 0) begin
          report($sformatf("unit %h with none expected", out_data_o.code_unit));
        end else begin
          want = expected_units.pop_front();
          if (out_data_o.code_unit !== want.code_unit)
            report($sformatf("code_unit %h, expected %h",
                             out_data_o.code_unit, want.code_unit));
          if (out_data_o.run_end !== want.run_end)
            report($sformatf("run_end %b, expected %b on unit %h",
                             out_data_o.run_end, want.run_end, want.code_unit));
          if (out_data_o.string_end !== want.string_end)
            report($sformatf("string_end %b, expected %b on unit %h",
                             out_data_o.string_end, want.string_end,
                             want.code_unit));
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    in_t beat;
    beat.data_byte  = b;
    beat.final_byte = fin;
    byte_q = {byte_q, beat};
    bytes_queued++;
  endtask

  // Stage the first keep bytes of an nb-byte encoding of cp
  task automatic stage_point(input logic [20:0] cp, input int nb, input int keep);
    logic [7:0] enc[4];
    case (nb)
      1: enc[0] = cp[7:0];
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) string_bytes = {string_bytes, enc[i]};
  endtask

  function automatic int natural_len(input logic [20:0] cp);
    return (cp < MIN_TWO_BYTE) ? 1 : (cp < MIN_THREE) ? 2 : (cp < SUPP_BASE) ? 3 : 4;
  endfunction

  // Build one random string, mostly well formed, and flag its last byte
  task automatic add_string();
    int          len;
    int          pick;
    int          nb;
    logic [20:0] cp;
    len = $urandom_range(1, 8);
    string_bytes.delete();
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        stage_point(21'($urandom_range(0, 'h7F)), 1, 1);
      end else if (pick < 45) begin
        stage_point(21'($urandom_range('h80, 'h7FF)), 2, 2);
      end else if (pick < 62) begin
        stage_point(21'($urandom_range('h800, 'hFFFF)), 3, 3);
      end else if (pick < 75) begin
        stage_point(21'($urandom_range('h10000, 'h10FFFF)), 4, 4);
      end else if (pick < 79) begin
        // overlong: more bytes than the value needs
        nb = $urandom_range(2, 4);
        cp = 21'((nb == 2) ? $urandom_range(0, 'h7F) :
                 (nb == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF));
        stage_point(cp, nb, nb);
      end else if (pick < 82) begin
        stage_point(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
      end else if (pick < 86) begin
        string_bytes = {string_bytes, 8'($urandom_range('h80, 'hBF))};
      end else if (pick < 89) begin
        string_bytes = {string_bytes, 8'($urandom_range('hF8, 'hFF))};
      end else if (pick < 95) begin
        // cut a sequence short; the next byte or the string end breaks it
        cp = 21'($urandom_range('h80, 'h10FFFF));
        nb = natural_len(cp);
        stage_point(cp, nb, $urandom_range(1, nb - 1));
      end else begin
        string_bytes = {string_bytes, 8'($urandom_range(0, 255))};
      end
    end
    for (int i = 0; i < string_bytes.size(); i++)
      queue_byte(string_bytes[i], i == string_bytes.size() - 1);
  endtask

  // Wait until every byte is taken and every unit has come, then let it settle
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_units.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode, input int send_pct, input int recv_pct);
    idle_mode     = mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Stimulus
  initial begin
    int phase_start;
    clear_sequence();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    set_idling(0, 35, 52);

    // Directed: ASCII extremes, overlong, smallest three-byte, surrogate,
    // largest and out-of-range point, stray, invalid lead, interruption,
    // truncation on a continuation and on a lead byte
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hC0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hE0, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hF4, 1'b0); queue_byte(8'h8F, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'h80, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h41, 1'b0);
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b1);
    queue_byte(8'hC3, 1'b1);
    wait_drained();

    // Random strings in three idling modes
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       set_idling(0, 35, 52);
        1:       set_idling(1, 52, 35);
        default: set_idling(2, 0, 0);
      endcase
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 530) add_string();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (expected_units.size() != 0)
      report($sformatf("%0d units never came", expected_units.size()));
    if (mismatches == 0) begin
      $display("utf8_to_utf16_transcoder test passed");
    end else begin
      $display("utf8_to_utf16_transcoder test failed");
    end
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering bytes
  initial begin
    wait (idle_mode == 2);
    repeat (30) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Timeout
  initial begin
    #4_000_000;
    $display("utf8_to_utf16_transcoder test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/utt_pkg.sv
design/utt_decode.sv
design/utt_out_buf.sv
design/utf8_to_utf16_transcoder.sv
dv/tb_top.sv
